>>> hw/rtl/hnf_pkg.sv
`default_nettype none

package hnf_pkg;

	localparam int VALUE_W = 20;
	localparam int COUNT_W = 16;
	localparam int CONV_W = 5;
	localparam int ACC_DIGITS = 3;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value_out;
		logic is_leader;
		logic [COUNT_W-1:0] leader_count;
		logic last_out;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_CHECK,
		ST_SUM,
		ST_LOAD,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_DABBLE,
		CELL_SHIFT,
		CELL_LOAD
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctl_t;

	typedef struct packed {
		logic clear;
		logic add;
	} acc_ctl_t;

	function automatic logic [63:0] pow10(input int n);
		logic [63:0] r;
		r = 64'd1;
		for (int i = 0; i < n; i++) begin
			r = r * 64'd10;
		end
		return r;
	endfunction

	// square of one decimal digit, as two BCD digits
	function automatic logic [7:0] sq_bcd(input logic [3:0] d);
		logic [7:0] r;
		case (d)
			4'd0: r = 8'h00;
			4'd1: r = 8'h01;
			4'd2: r = 8'h04;
			4'd3: r = 8'h09;
			4'd4: r = 8'h16;
			4'd5: r = 8'h25;
			4'd6: r = 8'h36;
			4'd7: r = 8'h49;
			4'd8: r = 8'h64;
			4'd9: r = 8'h81;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hnf_cell.sv
`default_nettype none

module hnf_cell import hnf_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic [3:0] load_digit,
	input  logic [3:0] shift_in,
	input  logic      dabble_in,
	output logic      dabble_out,
	output logic [3:0] digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	assign adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign dabble_out = adj[3];
	assign digit = digit_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_CLEAR:  digit_q <= 4'd0;
			CELL_DABBLE: digit_q <= {adj[2:0], dabble_in};
			CELL_SHIFT:  digit_q <= shift_in;
			CELL_LOAD:   digit_q <= load_digit;
			default:     digit_q <= digit_q;
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/hnf_acc.sv
`default_nettype none

module hnf_acc import hnf_pkg::*; (
	input  logic                  clk,
	input  acc_ctl_t              ctl,
	input  logic [3:0]            digit,
	output logic [4*ACC_DIGITS-1:0] bcd
);

	logic [4*ACC_DIGITS-1:0] acc_q;
	logic [4*ACC_DIGITS-1:0] sum;

	always_comb begin
		logic [4*ACC_DIGITS-1:0] sq;
		logic [3:0] addend;
		logic [4:0] s;
		logic carry;
		sq = {{(4*ACC_DIGITS-8){1'b0}}, sq_bcd(digit)};
		carry = 1'b0;
		sum = '0;
		for (int i = 0; i < ACC_DIGITS; i++) begin
			addend = sq[i*4 +: 4];
			s = {1'b0, acc_q[i*4 +: 4]} + {1'b0, addend} + {4'd0, carry};
			if (s > 5'd9) begin
				s = s + 5'd6;
				carry = 1'b1;
			end else begin
				carry = 1'b0;
			end
			sum[i*4 +: 4] = s[3:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.add) begin
			acc_q <= sum;
		end
	end

	assign bcd = acc_q;

endmodule

`default_nettype wire

>>> hw/rtl/happy_number_filter.sv
`default_nettype none

// Happy number filter. Each transaction on src carries one value; one result per value
// comes out on dst in order, with the value, a leader flag (nonzero happy number) and a
// running leader count that saturates at 65535 and restarts after a transaction marked
// last. One value is worked on at a time. The value is converted to decimal in a row of
// digit cells (one input bit per cycle), then each digit-square-sum step shifts the digits
// out of the row into a BCD accumulator and loads the sum back for the 1/4 test. At most
// MAX_STEPS steps are made, and a value that has not reached 1 or 4 by then is not
// flagged; zero and values of 10^DIGITS or more skip the conversion, are not flagged and
// go straight to the result. A finished result waits in the output register while the
// next value is accepted.
module happy_number_filter import hnf_pkg::*; #(
	parameter int DIGITS = 6,
	parameter int MAX_STEPS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_item_t  src_data,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_item_t dst_data
);

	localparam int CELLS = (DIGITS < ACC_DIGITS) ? ACC_DIGITS : DIGITS;
	localparam int SCW = $clog2(CELLS);
	localparam int STEP_W = $clog2(MAX_STEPS + 1);
	localparam logic [63:0] LIMIT = pow10(DIGITS);

	state_t state_q, state_d;
	cell_ctl_t cell_ctl;
	acc_ctl_t acc_ctl;
	logic write_out;
	logic accept;

	logic [VALUE_W-1:0] bin_q;
	logic [VALUE_W-1:0] val_q;
	logic last_q;
	logic lead_q;
	logic [CONV_W-1:0] conv_cnt_q;
	logic [SCW-1:0] sum_cnt_q;
	logic [STEP_W-1:0] step_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] cnt_next;
	out_item_t out_q;
	logic out_valid_q;

	logic [3:0] dig [CELLS];
	logic dab [CELLS];
	logic [4*ACC_DIGITS-1:0] acc_bcd;
	logic upper_zero, is_one, is_four, skip;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		logic [3:0] ld;
		logic [3:0] sh;
		logic din;
		if (i < ACC_DIGITS) begin : g_ld
			assign ld = acc_bcd[i*4 +: 4];
		end else begin : g_ld0
			assign ld = 4'd0;
		end
		if (i == CELLS - 1) begin : g_top
			assign sh = 4'd0;
		end else begin : g_mid
			assign sh = dig[i+1];
		end
		if (i == 0) begin : g_lsd
			assign din = bin_q[VALUE_W-1];
		end else begin : g_up
			assign din = dab[i-1];
		end
		hnf_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.load_digit (ld),
			.shift_in   (sh),
			.dabble_in  (din),
			.dabble_out (dab[i]),
			.digit      (dig[i])
		);
	end

	hnf_acc u_acc (
		.clk   (clk),
		.ctl   (acc_ctl),
		.digit (dig[0]),
		.bcd   (acc_bcd)
	);

	always_comb begin
		upper_zero = 1'b1;
		for (int i = 1; i < CELLS; i++) begin
			if (dig[i] != 4'd0) begin
				upper_zero = 1'b0;
			end
		end
	end

	assign is_one = upper_zero && (dig[0] == 4'd1);
	assign is_four = upper_zero && (dig[0] == 4'd4);
	assign skip = (src_data.value == '0) ||
		({{(64-VALUE_W){1'b0}}, src_data.value} >= LIMIT);
	assign accept = src_valid && !src_stall;
	assign src_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cell_ctl.op = CELL_HOLD;
		acc_ctl = '0;
		write_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (src_valid) begin
					cell_ctl.op = CELL_CLEAR;
					state_d = skip ? ST_DONE : ST_CONV;
				end
			end
			ST_CONV: begin
				cell_ctl.op = CELL_DABBLE;
				if (conv_cnt_q == CONV_W'(VALUE_W - 1)) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (is_one || is_four || step_q == STEP_W'(MAX_STEPS)) begin
					state_d = ST_DONE;
				end else begin
					acc_ctl.clear = 1'b1;
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				cell_ctl.op = CELL_SHIFT;
				acc_ctl.add = 1'b1;
				if (sum_cnt_q == SCW'(CELLS - 1)) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cell_ctl.op = CELL_LOAD;
				state_d = ST_CHECK;
			end
			ST_DONE: begin
				if (!out_valid_q || !dst_stall) begin
					write_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= src_data.value;
			val_q <= src_data.value;
			last_q <= src_data.last;
			lead_q <= 1'b0;
			conv_cnt_q <= '0;
			step_q <= '0;
		end
		if (state_q == ST_CONV) begin
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
			conv_cnt_q <= conv_cnt_q + 1'b1;
		end
		if (state_q == ST_CHECK) begin
			lead_q <= is_one;
			sum_cnt_q <= '0;
			step_q <= step_q + 1'b1;
		end
		if (state_q == ST_SUM) begin
			sum_cnt_q <= sum_cnt_q + 1'b1;
		end
		if (write_out) begin
			out_q.value_out <= val_q;
			out_q.is_leader <= lead_q;
			out_q.leader_count <= cnt_next;
			out_q.last_out <= last_q;
		end
	end

	assign cnt_next = (lead_q && cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (write_out) begin
				cnt_q <= last_q ? '0 : cnt_next;
				out_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_data = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/hnf_checker.sv
`default_nettype none

module hnf_checker import hnf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      src_valid,
	input logic      src_stall,
	input in_item_t  src_data,
	input logic      dst_valid,
	input logic      dst_stall,
	input out_item_t dst_data
);

	logic dst_acc;
	logic prev_last_q;
	logic [COUNT_W-1:0] prev_cnt_q;

	assign dst_acc = dst_valid && !dst_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_last_q <= 1'b1;
			prev_cnt_q <= '0;
		end else if (dst_acc) begin
			prev_last_q <= dst_data.last_out;
			prev_cnt_q <= dst_data.leader_count;
		end
	end

	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall |=> src_stall)
		else $error("transaction accepted while busy");

	a_leader_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.is_leader |-> dst_data.value_out != '0)
		else $error("zero flagged as leader");

	a_count_restart: assert property (@(posedge clk) disable iff (!arst_n)
		dst_acc && prev_last_q |->
			dst_data.leader_count == {{(COUNT_W-1){1'b0}}, dst_data.is_leader})
		else $error("count did not restart after last");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		dst_acc && !prev_last_q |->
			dst_data.leader_count == ((prev_cnt_q == '1) ? prev_cnt_q :
				prev_cnt_q + {{(COUNT_W-1){1'b0}}, dst_data.is_leader}))
		else $error("count step wrong");

endmodule

bind happy_number_filter hnf_checker u_hnf_checker (.*);

`default_nettype wire
